@@ rtl/alu8_pkg.sv @@
// ----------------------------------------------------------------------------
// alu8_pkg
// Shared types and constants for the 8-bit CPU ALU: command codes, flag bit
// positions and the operand and result bundles.
// ----------------------------------------------------------------------------
package alu8_pkg;

	// Command codes carried on the slave tuser
	typedef enum logic [4:0] {
		CMD_ADD   = 5'd0,
		CMD_ADC   = 5'd1,
		CMD_SUB   = 5'd2,
		CMD_SBC   = 5'd3,
		CMD_AND   = 5'd4,
		CMD_OR    = 5'd5,
		CMD_XOR   = 5'd6,
		CMD_CP    = 5'd7,
		CMD_INC8  = 5'd8,
		CMD_DEC8  = 5'd9,
		CMD_RLC   = 5'd10,
		CMD_RL    = 5'd11,
		CMD_RRC   = 5'd12,
		CMD_RR    = 5'd13,
		CMD_SLA   = 5'd14,
		CMD_SRA   = 5'd15,
		CMD_SRL   = 5'd16,
		CMD_SWAP  = 5'd17,
		CMD_BIT   = 5'd18,
		CMD_DAA   = 5'd19,
		CMD_CPL   = 5'd20,
		CMD_SCF   = 5'd21,
		CMD_CCF   = 5'd22,
		CMD_ADD16 = 5'd23,
		CMD_ADDSP = 5'd24,
		CMD_INC16 = 5'd25,
		CMD_DEC16 = 5'd26
	} cmd_t;

	// Flag byte layout
	localparam int unsigned FLAG_Z = 7;
	localparam int unsigned FLAG_N = 6;
	localparam int unsigned FLAG_H = 5;
	localparam int unsigned FLAG_C = 4;

	// BCD correction constants
	localparam logic [7:0] DAA_LO_FIX = 8'h06;
	localparam logic [7:0] DAA_HI_FIX = 8'h60;
	localparam logic [7:0] DAA_HI_LIM = 8'h99;
	localparam logic [3:0] DAA_LO_LIM = 4'h9;

	// One operation as it enters the ALU
	typedef struct packed {
		logic [4:0]  command;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [2:0]  bit_index;
		logic [7:0]  flags_in;
	} alu_in_t;

	// One finished operation
	typedef struct packed {
		logic [7:0]  flags_out;
		logic [15:0] result;
	} alu_out_t;

endpackage

@@ rtl/eight_bit_cpu_alu_with_flags.sv @@
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags
// Stream-wrapped 8-bit CPU ALU with Z/N/H/C flags.
// ----------------------------------------------------------------------------
// One operation per beat, one result beat per operation, in order. A beat
// accepted on the slave side is captured in the input register, passes the
// single-pass ALU logic and lands in the result register, from which it
// reaches the master side. With the master side ready the block sustains one
// beat every cycle; the input register and the result register let a new beat
// in while a finished result still waits. No state carries from one
// operation to the next.
module eight_bit_cpu_alu_with_flags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] operand_a, [31:16] operand_b, [34:32] bit_index,
	// [42:35] flags_in, [47:43] zero
	input  logic [47:0] s_axis_tdata,
	// [4:0] command
	input  logic [4:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] result, [23:16] flags_out
	output logic [23:0] m_axis_tdata
);

	logic                valid_s1;
	alu8_pkg::alu_in_t   op_s1;
	logic                valid_s2;
	alu8_pkg::alu_out_t  res_s2;
	alu8_pkg::alu_out_t  res_c;
	logic                adv_s2;
	logic                adv_s1;

	// Stage handshake
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			op_s1.command   <= s_axis_tuser;
			op_s1.operand_a <= s_axis_tdata[15:0];
			op_s1.operand_b <= s_axis_tdata[31:16];
			op_s1.bit_index <= s_axis_tdata[34:32];
			op_s1.flags_in  <= s_axis_tdata[42:35];
		end
	end

	alu8_core u_core (
		.op  (op_s1),
		.res (res_c)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

endmodule

@@ rtl/alu8_core.sv @@
// ----------------------------------------------------------------------------
// alu8_core
// Single-pass combinational datapath: arithmetic, logic, rotates and shifts, BCD adjust
// and 16-bit adds, with Z/N/H/C flag update.
// ----------------------------------------------------------------------------
module alu8_core (
	input  alu8_pkg::alu_in_t  op,
	output alu8_pkg::alu_out_t res
);

	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin;
	logic        cin_add;
	logic        cin_sub;
	logic [8:0]  sum8;
	logic [4:0]  sum4;
	logic [8:0]  dif8;
	logic [4:0]  dif4;
	logic [16:0] sum16;
	logic [12:0] sum12;
	logic [15:0] ext_b;
	logic        daa_lo;
	logic        daa_hi;
	logic [7:0]  daa_off;
	logic [7:0]  daa_r;
	logic [15:0] r;
	logic        fz;
	logic        fn;
	logic        fh;
	logic        fc;

	assign a   = op.operand_a[7:0];
	assign b   = op.operand_b[7:0];
	assign cin = op.flags_in[alu8_pkg::FLAG_C];

	// Carry-in only for the with-carry forms
	assign cin_add = (op.command == alu8_pkg::CMD_ADC) ? cin : 1'b0;
	assign cin_sub = (op.command == alu8_pkg::CMD_SBC) ? cin : 1'b0;

	// 8-bit adder and subtractor, nibble carries for H
	assign sum8 = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
	assign sum4 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
	assign dif8 = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
	assign dif4 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};

	// 16-bit adds
	assign sum16 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
	assign sum12 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
	assign ext_b = {{8{b[7]}}, b};

	// Decimal adjust
	assign daa_lo  = (!op.flags_in[alu8_pkg::FLAG_N] && (a[3:0] > alu8_pkg::DAA_LO_LIM))
		|| op.flags_in[alu8_pkg::FLAG_H];
	assign daa_hi  = (!op.flags_in[alu8_pkg::FLAG_N] && (a > alu8_pkg::DAA_HI_LIM))
		|| op.flags_in[alu8_pkg::FLAG_C];
	assign daa_off = (daa_lo ? alu8_pkg::DAA_LO_FIX : 8'h00)
		| (daa_hi ? alu8_pkg::DAA_HI_FIX : 8'h00);
	assign daa_r   = op.flags_in[alu8_pkg::FLAG_N] ? (a - daa_off) : (a + daa_off);

	// Command decode; untouched flags keep their incoming value
	always_comb begin
		r  = op.operand_a;
		fz = op.flags_in[alu8_pkg::FLAG_Z];
		fn = op.flags_in[alu8_pkg::FLAG_N];
		fh = op.flags_in[alu8_pkg::FLAG_H];
		fc = op.flags_in[alu8_pkg::FLAG_C];
		unique case (op.command)
			alu8_pkg::CMD_ADD, alu8_pkg::CMD_ADC: begin
				r  = {8'd0, sum8[7:0]};
				fz = (sum8[7:0] == 8'd0);
				fn = 1'b0;
				fh = sum4[4];
				fc = sum8[8];
			end
			alu8_pkg::CMD_SUB, alu8_pkg::CMD_SBC, alu8_pkg::CMD_CP: begin
				if (op.command != alu8_pkg::CMD_CP) begin
					r = {8'd0, dif8[7:0]};
				end
				fz = (dif8[7:0] == 8'd0);
				fn = 1'b1;
				fh = dif4[4];
				fc = dif8[8];
			end
			alu8_pkg::CMD_AND: begin
				r  = {8'd0, a & b};
				fz = ((a & b) == 8'd0);
				fn = 1'b0;
				fh = 1'b1;
				fc = 1'b0;
			end
			alu8_pkg::CMD_OR: begin
				r  = {8'd0, a | b};
				fz = ((a | b) == 8'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = 1'b0;
			end
			alu8_pkg::CMD_XOR: begin
				r  = {8'd0, a ^ b};
				fz = ((a ^ b) == 8'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = 1'b0;
			end
			alu8_pkg::CMD_INC8: begin
				r  = {8'd0, a + 8'd1};
				fz = (a == 8'hFF);
				fn = 1'b0;
				fh = (a[3:0] == 4'hF);
			end
			alu8_pkg::CMD_DEC8: begin
				r  = {8'd0, a - 8'd1};
				fz = (a == 8'h01);
				fn = 1'b1;
				fh = (a[3:0] == 4'h0);
			end
			alu8_pkg::CMD_RLC: begin
				r  = {8'd0, a[6:0], a[7]};
				fz = (a == 8'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = a[7];
			end
			alu8_pkg::CMD_RL: begin
				r  = {8'd0, a[6:0], cin};
				fz = ({a[6:0], cin} == 8'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = a[7];
			end
			alu8_pkg::CMD_RRC: begin
				r  = {8'd0, a[0], a[7:1]};
				fz = (a == 8'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = a[0];
			end
			alu8_pkg::CMD_RR: begin
				r  = {8'd0, cin, a[7:1]};
				fz = ({cin, a[7:1]} == 8'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = a[0];
			end
			alu8_pkg::CMD_SLA: begin
				r  = {8'd0, a[6:0], 1'b0};
				fz = (a[6:0] == 7'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = a[7];
			end
			alu8_pkg::CMD_SRA: begin
				r  = {8'd0, a[7], a[7:1]};
				fz = (a[7:1] == 7'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = a[0];
			end
			alu8_pkg::CMD_SRL: begin
				r  = {8'd0, 1'b0, a[7:1]};
				fz = (a[7:1] == 7'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = a[0];
			end
			alu8_pkg::CMD_SWAP: begin
				r  = {8'd0, a[3:0], a[7:4]};
				fz = (a == 8'd0);
				fn = 1'b0;
				fh = 1'b0;
				fc = 1'b0;
			end
			alu8_pkg::CMD_BIT: begin
				fz = !a[op.bit_index];
				fn = 1'b0;
				fh = 1'b1;
			end
			alu8_pkg::CMD_DAA: begin
				r  = {8'd0, daa_r};
				fz = (daa_r == 8'd0);
				fh = 1'b0;
				fc = fc | daa_hi;
			end
			alu8_pkg::CMD_CPL: begin
				r  = {8'd0, ~a};
				fn = 1'b1;
				fh = 1'b1;
			end
			alu8_pkg::CMD_SCF: begin
				fn = 1'b0;
				fh = 1'b0;
				fc = 1'b1;
			end
			alu8_pkg::CMD_CCF: begin
				fn = 1'b0;
				fh = 1'b0;
				fc = !cin;
			end
			alu8_pkg::CMD_ADD16: begin
				r  = sum16[15:0];
				fn = 1'b0;
				fh = sum12[12];
				fc = sum16[16];
			end
			alu8_pkg::CMD_ADDSP: begin
				// H and C come from the unsigned low-byte add
				r  = op.operand_a + ext_b;
				fz = 1'b0;
				fn = 1'b0;
				fh = sum4[4];
				fc = sum8[8];
			end
			alu8_pkg::CMD_INC16: begin
				r = op.operand_a + 16'd1;
			end
			alu8_pkg::CMD_DEC16: begin
				r = op.operand_a - 16'd1;
			end
			default: begin
				// unused codes pass operand and flags through
				r = op.operand_a;
			end
		endcase
	end

	assign res.result    = r;
	assign res.flags_out = {fz, fn, fh, fc, op.flags_in[3:0]};

endmodule

@@ rtl/alu8_checker.sv @@
// ----------------------------------------------------------------------------
// alu8_checker
// Port-level checks on the ALU stream wrapper, bound to the top level.
// ----------------------------------------------------------------------------
module alu8_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [47:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Input only backs up when both stages are full and the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// Accepted beat passes both registers to the master side when the output keeps up
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("result beat missing after two cycles");

	// Low nibble of the flag byte passes through
	a_low_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready
		|=> m_axis_tdata[19:16] == $past(s_axis_tdata[38:35], 2))
		else $error("low flag nibble not passed through");

endmodule

bind eight_bit_cpu_alu_with_flags alu8_checker u_alu8_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
